@@ rtl/iala_pkg.sv @@
// Shared types and constants for the indexed array list core.
package iala_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_IN_W = 7;
  localparam int CMP_W    = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
  localparam int DATA_W   = 32;
  localparam int GRP      = 8;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_GET    = 3'd3,
    REQ_SET    = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_e;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SET,
    CELL_GET
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FOLD,
    S_RESP
  } state_e;

  typedef struct packed {
    cell_op_e                op;
    logic [CMP_W-1:0]        idx;
    logic [DATA_W-1:0]       val;
  } cell_cmd_t;

endpackage

@@ rtl/indexed_array_list_core.sv @@
// Top level of the indexed array list: sequencer, row of list cells, read fold.
//
//  channel   signals                                        handshake
//  request   start_i, req_type_i, index_i, value_i          start_i && !busy_o
//  result    read_value_o, status_o, count_o, empty_res_o   done_o, one cycle
//
// A transaction runs through capture, execute in the cell row (all entries
// shift together), fold of the read data in groups of 8, and result.
// busy_o is high from capture until the result cycle ends.
// Reset clears the count and sequencer; entry contents are not cleared.
// The result strobe cannot be stalled by the receiver.
module indexed_array_list_core
  import iala_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [2:0]           req_type_i,
  input  logic [IDX_IN_W-1:0]  index_i,
  input  logic signed [31:0]   value_i,
  output logic                 done_o,
  output logic signed [31:0]   read_value_o,
  output logic [1:0]           status_o,
  output logic [6:0]           count_o,
  output logic                 empty_res_o
);

  cell_cmd_t          cmd;
  logic               fold;
  logic [DATA_W-1:0]  cell_val [CAPACITY];
  logic [DATA_W-1:0]  cell_rd  [CAPACITY];
  logic [DATA_W-1:0]  grp_q    [NGRP];
  logic [DATA_W-1:0]  grp_d    [NGRP];
  logic [DATA_W-1:0]  rd_all;

  iala_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_type_i  (req_type_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .fold_o      (fold),
    .done_o      (done_o),
    .cmd_o       (cmd),
    .status_o    (status_o),
    .count_o     (count_o),
    .empty_res_o (empty_res_o)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_val[i+1];
    end
    iala_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (CMP_W'(i)),
      .left_i  (left),
      .right_i (right),
      .val_o   (cell_val[i]),
      .rd_o    (cell_rd[i])
    );
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          grp_d[g] = grp_d[g] | cell_rd[g * GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fold) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    rd_all = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_all = rd_all | grp_q[g];
    end
  end

  assign read_value_o = rd_all;

endmodule

@@ rtl/iala_cell.sv @@
// One list slot: holds an entry and shifts with its neighbors on insert and remove.
module iala_cell
  import iala_pkg::*;
(
  input  logic                clk_i,
  input  cell_cmd_t           cmd_i,
  input  logic [CMP_W-1:0]    pos_i,
  input  logic [DATA_W-1:0]   left_i,
  input  logic [DATA_W-1:0]   right_i,
  output logic [DATA_W-1:0]   val_o,
  output logic [DATA_W-1:0]   rd_o
);

  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] rd_q, rd_d;
  logic              hit;

  assign hit = (pos_i == cmd_i.idx);

  always_comb begin
    val_d = val_q;
    rd_d  = '0;
    unique case (cmd_i.op)
      CELL_INSERT: begin
        if (hit) begin
          val_d = cmd_i.val;
        end else if (pos_i > cmd_i.idx) begin
          val_d = left_i;
        end
      end
      CELL_REMOVE: begin
        if (pos_i >= cmd_i.idx) begin
          val_d = right_i;
        end
      end
      CELL_SET: begin
        if (hit) begin
          val_d = cmd_i.val;
        end
      end
      CELL_GET: begin
        if (hit) begin
          rd_d = val_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rd_q  <= rd_d;
  end

  assign val_o = val_q;
  assign rd_o  = rd_q;

endmodule

@@ rtl/iala_ctrl.sv @@
// Sequencer: holds the entry count, checks requests and drives the cell row.
module iala_ctrl
  import iala_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [2:0]           req_type_i,
  input  logic [IDX_IN_W-1:0]  index_i,
  input  logic [DATA_W-1:0]    value_i,
  output logic                 busy_o,
  output logic                 fold_o,
  output logic                 done_o,
  output cell_cmd_t            cmd_o,
  output logic [1:0]           status_o,
  output logic [6:0]           count_o,
  output logic                 empty_res_o
);

  state_e             state_q, state_d;
  logic [2:0]         req_q;
  logic [CMP_W-1:0]   idx_q;
  logic [DATA_W-1:0]  val_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [1:0]         status_q, status_d;
  logic [CMP_W-1:0]   cnt_ext;
  logic               full;
  logic               accept;

  assign accept  = start_i && (state_q == S_IDLE);
  assign cnt_ext = CMP_W'(count_q);
  assign full    = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start_i) state_d = S_EXEC;
      S_EXEC:  state_d = S_FOLD;
      S_FOLD:  state_d = S_RESP;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op  = CELL_HOLD;
    cmd_o.idx = idx_q;
    cmd_o.val = val_q;
    count_d   = count_q;
    status_d  = status_q;
    if (state_q == S_EXEC) begin
      status_d = STATUS_OK;
      unique case (req_q)
        REQ_APPEND: begin
          if (full) begin
            status_d = STATUS_FULL;
          end else begin
            cmd_o.op  = CELL_INSERT;
            cmd_o.idx = cnt_ext;
            count_d   = count_q + 1'b1;
          end
        end
        REQ_INSERT: begin
          if (idx_q > cnt_ext) begin
            status_d = STATUS_RANGE;
          end else if (full) begin
            status_d = STATUS_FULL;
          end else begin
            cmd_o.op = CELL_INSERT;
            count_d  = count_q + 1'b1;
          end
        end
        REQ_REMOVE: begin
          if (idx_q >= cnt_ext) begin
            status_d = STATUS_RANGE;
          end else begin
            cmd_o.op = CELL_REMOVE;
            count_d  = count_q - 1'b1;
          end
        end
        REQ_GET: begin
          if (idx_q >= cnt_ext) status_d = STATUS_RANGE;
          else cmd_o.op = CELL_GET;
        end
        REQ_SET: begin
          if (idx_q >= cnt_ext) status_d = STATUS_RANGE;
          else cmd_o.op = CELL_SET;
        end
        REQ_CLEAR: count_d = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (accept) begin
      req_q <= req_type_i;
      idx_q <= CMP_W'(index_i);
      val_q <= value_i;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign fold_o      = (state_q == S_FOLD);
  assign done_o      = (state_q == S_RESP);
  assign status_o    = status_q;
  assign count_o     = 7'(count_q);
  assign empty_res_o = (count_q == '0);

endmodule

@@ sim/indexed_array_list_core_test.sv @@
// Self-checking testbench for the indexed array list core: directed and random requests.
module indexed_array_list_core_test;
  import iala_pkg::*;

  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam int N_RANDOM     = 1400;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [2:0]  req;
    logic [6:0]  idx;
    logic [31:0] val;
    logic        drain;
  } list_req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [6:0]  count;
    logic        empty;
  } list_result_t;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               start_i    = 1'b0;
  logic [2:0]         req_type_i = '0;
  logic [6:0]         index_i    = '0;
  logic signed [31:0] value_i    = '0;
  logic               busy_o;
  logic               done_o;
  logic signed [31:0] read_value_o;
  logic [1:0]         status_o;
  logic [6:0]         count_o;
  logic               empty_res_o;

  list_req_t    pending_q[$];
  list_result_t expected_q[$];
  logic [31:0]  list_mem [CAPACITY];
  int           list_len     = 0;
  int           gen_len      = 0;
  int           accepted     = 0;
  int           mismatches   = 0;
  int           stall_cycles = 0;
  int           full_hits    = 0;
  int           range_hits   = 0;
  int           peak_len     = 0;
  int           idle_table [3] = '{0, 70, 27};

  indexed_array_list_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_o      (count_o),
    .empty_res_o  (empty_res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic list_result_t apply_request(list_req_t r);
    list_result_t res;
    res = '0;
    case (r.req)
      REQ_APPEND: begin
        if (list_len >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          list_mem[list_len] = r.val;
          list_len++;
        end
      end
      REQ_INSERT: begin
        if (int'(r.idx) > list_len) begin
          res.status = STATUS_RANGE;
        end else if (list_len >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          for (int i = list_len; i > int'(r.idx); i--) list_mem[i] = list_mem[i-1];
          list_mem[r.idx] = r.val;
          list_len++;
        end
      end
      REQ_REMOVE: begin
        if (int'(r.idx) >= list_len) begin
          res.status = STATUS_RANGE;
        end else begin
          for (int i = int'(r.idx); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      REQ_GET: begin
        if (int'(r.idx) >= list_len) res.status = STATUS_RANGE;
        else res.read_value = list_mem[r.idx];
      end
      REQ_SET: begin
        if (int'(r.idx) >= list_len) res.status = STATUS_RANGE;
        else list_mem[r.idx] = r.val;
      end
      REQ_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    res.count = list_len[6:0];
    res.empty = (list_len == 0);
    if (res.status == STATUS_FULL) full_hits++;
    if (res.status == STATUS_RANGE) range_hits++;
    if (list_len > peak_len) peak_len = list_len;
    return res;
  endfunction

  // Queues a request and tracks the list length it leaves behind.
  task automatic queue_req(logic [2:0] req, logic [6:0] idx, logic [31:0] val, logic drain);
    list_req_t r;
    r = '{req: req, idx: idx, val: val, drain: drain};
    pending_q.push_back(r);
    case (req)
      REQ_APPEND: if (gen_len < CAPACITY) gen_len++;
      REQ_INSERT: if (int'(idx) <= gen_len && gen_len < CAPACITY) gen_len++;
      REQ_REMOVE: if (int'(idx) < gen_len) gen_len--;
      REQ_CLEAR:  gen_len = 0;
      default: begin
      end
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin
    logic fire;
    int   idle_pct;
    fire     = start_i && !busy_o;
    idle_pct = idle_table[(accepted / 150) % 3];
    if (rst_ni) begin
      if (fire) begin
        expected_q.push_back(apply_request(pending_q.pop_front()));
        accepted++;
      end
      if (start_i && !fire) begin
        // hold the request until it is taken
      end else if (pending_q.size() == 0 || $urandom_range(99) < idle_pct ||
                   (pending_q[0].drain && (expected_q.size() != 0 || busy_o))) begin
        start_i <= 1'b0;
      end else begin
        start_i    <= 1'b1;
        req_type_i <= pending_q[0].req;
        index_i    <= pending_q[0].idx;
        value_i    <= pending_q[0].val;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    list_result_t act;
    list_result_t exp_res;
    act = '{read_value: read_value_o, status: status_o, count: count_o, empty: empty_res_o};
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: rd=%h st=%0d cnt=%0d empty=%0b",
                   act.read_value, act.status, act.count, act.empty);
      end else begin
        exp_res = expected_q.pop_front();
        if (act.read_value !== exp_res.read_value || act.status !== exp_res.status ||
            act.count !== exp_res.count || act.empty !== exp_res.empty) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: exp rd=%h st=%0d cnt=%0d empty=%0b, got rd=%h st=%0d cnt=%0d empty=%0b",
                     exp_res.read_value, exp_res.status, exp_res.count, exp_res.empty,
                     act.read_value, act.status, act.count, act.empty);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int          mode;
    int          pick;
    int          grow;
    int          sel;
    logic [2:0]  req;
    logic [6:0]  idx;
    logic [31:0] val;

    // directed: empty list, edges of index and value, every request code
    queue_req(REQ_GET,      7'd0,   32'h0,        1'b0);
    queue_req(REQ_REMOVE,   7'd0,   32'h0,        1'b0);
    queue_req(REQ_INSERT,   7'd1,   32'h1,        1'b0);
    queue_req(REQ_INSERT,   7'd0,   32'h7fff_ffff, 1'b0);
    queue_req(REQ_APPEND,   7'd127, 32'h8000_0000, 1'b0);
    queue_req(REQ_APPEND,   7'd0,   32'h0,        1'b0);
    queue_req(REQ_APPEND,   7'd0,   32'hffff_ffff, 1'b0);
    queue_req(REQ_INSERT,   7'd4,   32'h5555_5555, 1'b0);
    queue_req(REQ_INSERT,   7'd0,   32'haaaa_aaaa, 1'b0);
    queue_req(REQ_INSERT,   7'd7,   32'h1234_0000, 1'b0);
    queue_req(REQ_INSERT,   7'd127, 32'h1234_0001, 1'b0);
    queue_req(REQ_GET,      7'd0,   32'h0,        1'b0);
    queue_req(REQ_GET,      7'd5,   32'h0,        1'b0);
    queue_req(REQ_GET,      7'd6,   32'h0,        1'b0);
    queue_req(REQ_GET,      7'd127, 32'hffff_ffff, 1'b0);
    queue_req(REQ_SET,      7'd2,   32'h1234_5678, 1'b0);
    queue_req(REQ_SET,      7'd6,   32'hdead_beef, 1'b0);
    queue_req(REQ_GET,      7'd2,   32'h0,        1'b0);
    queue_req(REQ_REMOVE,   7'd5,   32'h0,        1'b0);
    queue_req(REQ_REMOVE,   7'd0,   32'h0,        1'b0);
    queue_req(REQ_REMOVE,   7'd9,   32'h0,        1'b0);
    queue_req(REQ_REMOVE,   7'd127, 32'h0,        1'b0);
    queue_req(REQ_SPARE_LO, 7'd127, 32'hffff_ffff, 1'b0);
    queue_req(REQ_SPARE_HI, 7'd1,   32'h8000_0000, 1'b0);
    queue_req(REQ_CLEAR,    7'd0,   32'h0,        1'b0);
    queue_req(REQ_GET,      7'd0,   32'h0,        1'b0);

    // random: stretches that grow, shrink or churn the list
    mode = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 50 == 0) mode = $urandom_range(2);
      grow = (mode == 0) ? 75 : ((mode == 1) ? 20 : 45);
      pick = $urandom_range(99);
      if (pick < 2) req = REQ_CLEAR;
      else if (pick < 5) req = $urandom_range(1) ? REQ_SPARE_LO : REQ_SPARE_HI;
      else if (pick < 5 + grow) req = $urandom_range(1) ? REQ_APPEND : REQ_INSERT;
      else begin
        case ($urandom_range(2))
          0:       req = REQ_REMOVE;
          1:       req = REQ_GET;
          default: req = REQ_SET;
        endcase
      end
      sel = $urandom_range(9);
      if (sel < 7) idx = 7'($urandom_range(gen_len));
      else if (sel == 7) idx = 7'(gen_len);
      else if (sel == 8) idx = (gen_len > 0) ? 7'(gen_len - 1) : 7'd0;
      else idx = 7'($urandom_range(127));
      case ($urandom_range(9))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7fff_ffff;
        2:       val = 32'h0;
        3:       val = 32'hffff_ffff;
        default: val = $urandom();
      endcase
      queue_req(req, idx, val, (n % 280) == 140);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests: %0d list-full and %0d bad-index statuses, peak length %0d of %0d.",
             accepted, full_hits, range_hits, peak_len, CAPACITY);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d bad results, %0d results missing", mismatches, expected_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/iala_pkg.sv
rtl/iala_cell.sv
rtl/iala_ctrl.sv
rtl/indexed_array_list_core.sv
sim/indexed_array_list_core_test.sv
